// ===== hw/rtl/vni_pkg.sv =====
// Package for the value noise interpolator: state codes, mode codes,
// configuration register indexes and the xorshift generator step.
// No dependencies.
package vni_pkg;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_PREP,
    ST_MUL,
    ST_DONE
  } state_e;

  // Interpolation modes.
  localparam logic [1:0] MODE_STEP   = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;
  localparam logic [1:0] MODE_COSINE = 2'd2;
  localparam logic [1:0] MODE_CUBIC  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_INTERP_MODE = 2'd0;
  localparam logic [1:0] CFG_CLIP_ENABLE = 2'd1;
  localparam logic [1:0] CFG_SEED        = 2'd2;

  // Register reset values.
  localparam logic [1:0]  RST_INTERP_MODE = MODE_CUBIC;
  localparam logic        RST_CLIP_ENABLE = 1'b0;
  localparam logic [31:0] RST_SEED        = 32'd1;

  // Pi in Q30, used when the cosine table is built at elaboration.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Xorshift shift amounts.
  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  // One step of the 32-bit xorshift generator.
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

endpackage

// ===== hw/rtl/value_noise_interpolator.sv =====
// Value noise interpolator: xorshift sample window, one shared multiplier; uses vni_pkg.
// The input stays closed from acceptance until the result is produced, so items never overlap;
// the pace is set by the Horner steps on the shared multiplier, which depend on the mode; a
// restart adds a window fill, and a stalled output holds the final state until the result register is free.
// Reset is asynchronous and active low; a window fill follows before input opens.
module value_noise_interpolator #(
  parameter int FRAC_BITS      = 16,
  parameter int COS_TABLE_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: step_increment [FRAC_BITS:0], zero padding above.
  input  logic [((FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: restart.
  input  logic                                 s_axis_tuser,
  // Output stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: noise_value [FRAC_BITS+2:0], zero padding above.
  output logic [((FRAC_BITS + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_idx_i,
  input  logic [31:0]                          cfg_data_i
);

  localparam int F       = FRAC_BITS;
  localparam int C       = COS_TABLE_BITS;
  localparam int W       = F + 4;              // accumulator, covers +/-8
  localparam int PW      = W + F + 2;          // product width
  localparam int OW      = F + 3;              // output width
  localparam int OUT_DW  = ((F + 3 + 7) / 8) * 8;
  localparam int TAB_N   = 1 << C;
  localparam int TAB_LEN = TAB_N + 1;
  localparam int IDX_W   = C + 1;
  localparam int SH_R    = (F >= C) ? F - C : 0;
  localparam int SH_L    = (F >= C) ? 0 : C - F;
  localparam int EXT_W   = F + 1 + SH_L;

  localparam logic [F:0]          ONE_P  = {1'b1, {F{1'b0}}};
  localparam logic signed [W-1:0] ONE_W  = {3'b000, 1'b1, {F{1'b0}}};
  localparam logic signed [W-1:0] SAT_HI = {2'b00, {(F + 2){1'b1}}};
  localparam logic signed [W-1:0] SAT_LO = {2'b11, {(F + 2){1'b0}}};
  localparam logic [IDX_W-1:0]    IDX_MAX = IDX_W'(TAB_N);

  // Raised-cosine table, entry k = round(2^F * (1 - cos(pi*k/2^C)) / 2),
  // built by an integer Taylor series for the lower half and by symmetry above.
  function automatic logic [TAB_LEN*(F+1)-1:0] build_cos_table();
    logic [TAB_LEN*(F+1)-1:0] tab;
    longint unsigned          theta;
    longint unsigned          term;
    longint                   sum;
    longint                   ent;
    tab = '0;
    for (int k = 0; k <= TAB_N / 2; k++) begin
      theta = (vni_pkg::PI_Q30 * 64'(k)) >> C;
      term  = 64'd1 << 30;
      sum   = 0;
      for (int m = 1; m <= 8; m++) begin
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = term / 64'((2 * m - 1) * (2 * m));
        if ((m % 2) == 1) begin
          sum = sum + longint'(term);
        end else begin
          sum = sum - longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      ent = (sum + (longint'(1) << (30 - F))) >>> (31 - F);
      tab[k*(F+1) +: F+1] = (F + 1)'(ent);
    end
    for (int k = TAB_N / 2 + 1; k <= TAB_N; k++) begin
      tab[k*(F+1) +: F+1] = ONE_P - tab[(TAB_N - k)*(F+1) +: F+1];
    end
    return tab;
  endfunction

  localparam logic [TAB_LEN*(F+1)-1:0] COS_TAB = build_cos_table();

  // Registers.
  vni_pkg::state_e state_q, state_d;
  logic [1:0]            mode_q;
  logic                  clip_q;
  logic [31:0]           seed_q;
  logic [31:0]           rng_q, rng_d;
  logic [F-1:0]          win_q [4];
  logic [F-1:0]          win_d [4];
  logic [F:0]            phase_q, phase_d;
  logic [F:0]            inc_q, inc_d;
  logic                  item_q, item_d;
  logic [1:0]            cnt_q, cnt_d;
  logic signed [W-1:0]   acc_q, acc_d;
  logic [F:0]            cos_q, cos_d;
  logic                  m_valid_q, m_valid_d;
  logic [OW-1:0]         out_q, out_d;

  // Datapath signals.
  logic [F-1:0]          sample;
  logic [F:0]            inc_in;
  logic                  need_shift;
  logic [F:0]            phase_sub;
  logic [F-1:0]          wn [4];
  logic signed [W-1:0]   n0, n1, n2, n3, p_new;
  logic signed [W-1:0]   v0, v1, v2, v3, q_cur, r_cur, addend;
  logic [EXT_W-1:0]      idx_ext;
  logic [IDX_W-1:0]      idx;
  logic [F:0]            mop;
  logic signed [PW-1:0]  prod;
  logic signed [W-1:0]   prod_sh;
  logic                  last_step;
  logic signed [W-1:0]   val_clip, val_sat;
  logic                  s_acc;

  assign s_axis_tready = (state_q == vni_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DW'(out_q);

  // Generator output is the top F bits of the state before it advances.
  assign sample = rng_q[31 -: F];

  // Increments above one count as one.
  assign inc_in = (s_axis_tdata[F:0] > ONE_P) ? ONE_P : s_axis_tdata[F:0];

  // Window after the optional shift when the phase has reached one.
  assign need_shift = (phase_q >= ONE_P);
  assign phase_sub  = need_shift ? (phase_q - ONE_P) : phase_q;
  always_comb begin
    if (need_shift) begin
      wn[0] = win_q[1];
      wn[1] = win_q[2];
      wn[2] = win_q[3];
      wn[3] = sample;
    end else begin
      wn[0] = win_q[0];
      wn[1] = win_q[1];
      wn[2] = win_q[2];
      wn[3] = win_q[3];
    end
  end

  assign n0    = $signed(W'(wn[0]));
  assign n1    = $signed(W'(wn[1]));
  assign n2    = $signed(W'(wn[2]));
  assign n3    = $signed(W'(wn[3]));
  assign p_new = (n3 - n2) - (n0 - n1);

  // Cubic coefficients from the settled window.
  assign v0    = $signed(W'(win_q[0]));
  assign v1    = $signed(W'(win_q[1]));
  assign v2    = $signed(W'(win_q[2]));
  assign v3    = $signed(W'(win_q[3]));
  assign q_cur = (v0 - v1) - ((v3 - v2) - (v0 - v1));
  assign r_cur = v2 - v0;

  // Cosine table index from the phase, truncated to the table resolution.
  assign idx_ext = (EXT_W'(phase_sub) << SH_L) >> SH_R;
  assign idx     = (idx_ext > EXT_W'(TAB_N)) ? IDX_MAX : idx_ext[IDX_W-1:0];

  // Shared multiplier: accumulator times phase or cosine weight, floored.
  assign mop     = (mode_q == vni_pkg::MODE_COSINE) ? cos_q : phase_q;
  assign prod    = PW'(acc_q) * $signed({1'b0, mop});
  assign prod_sh = W'(prod >>> F);

  always_comb begin
    if (mode_q == vni_pkg::MODE_CUBIC) begin
      unique case (cnt_q)
        2'd0:    addend = q_cur;
        2'd1:    addend = r_cur;
        default: addend = v1;
      endcase
    end else begin
      addend = v1;
    end
  end

  assign last_step = (mode_q != vni_pkg::MODE_CUBIC) || (cnt_q == 2'd2);

  // Optional clip for cubic, then saturation to the output range.
  always_comb begin
    val_clip = acc_q;
    if ((mode_q == vni_pkg::MODE_CUBIC) && clip_q) begin
      if (acc_q < 0) begin
        val_clip = '0;
      end else if (acc_q > ONE_W) begin
        val_clip = ONE_W;
      end
    end
    if (val_clip < SAT_LO) begin
      val_sat = SAT_LO;
    end else if (val_clip > SAT_HI) begin
      val_sat = SAT_HI;
    end else begin
      val_sat = val_clip;
    end
  end

  // Sequencer next state and datapath updates.
  always_comb begin
    state_d   = state_q;
    rng_d     = rng_q;
    win_d     = win_q;
    phase_d   = phase_q;
    inc_d     = inc_q;
    item_d    = item_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    cos_d     = cos_q;
    m_valid_d = m_valid_q;
    out_d     = out_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      vni_pkg::ST_IDLE: begin
        if (s_acc) begin
          inc_d  = inc_in;
          item_d = 1'b1;
          if (s_axis_tuser) begin
            rng_d   = seed_q;
            phase_d = '0;
            cnt_d   = '0;
            state_d = vni_pkg::ST_FILL;
          end else begin
            state_d = vni_pkg::ST_PREP;
          end
        end
      end
      vni_pkg::ST_FILL: begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = win_q[3];
        win_d[3] = sample;
        rng_d    = vni_pkg::xorshift32(rng_q);
        cnt_d    = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          cnt_d   = '0;
          state_d = item_q ? vni_pkg::ST_PREP : vni_pkg::ST_IDLE;
        end
      end
      vni_pkg::ST_PREP: begin
        win_d   = wn;
        phase_d = phase_sub;
        cos_d   = COS_TAB[idx*(F+1) +: F+1];
        cnt_d   = '0;
        if (need_shift) begin
          rng_d = vni_pkg::xorshift32(rng_q);
        end
        unique case (mode_q)
          vni_pkg::MODE_STEP: begin
            acc_d   = n1;
            state_d = vni_pkg::ST_DONE;
          end
          vni_pkg::MODE_CUBIC: begin
            acc_d   = p_new;
            state_d = vni_pkg::ST_MUL;
          end
          default: begin
            acc_d   = n2 - n1;
            state_d = vni_pkg::ST_MUL;
          end
        endcase
      end
      vni_pkg::ST_MUL: begin
        acc_d = prod_sh + addend;
        cnt_d = cnt_q + 2'd1;
        if (last_step) begin
          state_d = vni_pkg::ST_DONE;
        end
      end
      vni_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          out_d     = val_sat[OW-1:0];
          phase_d   = phase_q + inc_q;
          item_d    = 1'b0;
          state_d   = vni_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vni_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers; reset starts a window fill from the reset seed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vni_pkg::ST_FILL;
      rng_q     <= vni_pkg::RST_SEED;
      phase_q   <= '0;
      item_q    <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rng_q     <= rng_d;
      phase_q   <= phase_d;
      item_q    <= item_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= vni_pkg::RST_INTERP_MODE;
      clip_q <= vni_pkg::RST_CLIP_ENABLE;
      seed_q <= vni_pkg::RST_SEED;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vni_pkg::CFG_INTERP_MODE: mode_q <= cfg_data_i[1:0];
        vni_pkg::CFG_CLIP_ENABLE: clip_q <= cfg_data_i[0];
        vni_pkg::CFG_SEED:        seed_q <= cfg_data_i;
        default:                  ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    inc_q <= inc_d;
    acc_q <= acc_d;
    cos_q <= cos_d;
    out_q <= out_d;
  end

`ifndef SYNTH
  // An accepted transaction closes the input until its result is produced.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted again while an item is in progress");

  // The phase is below one whenever the multiplier uses it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vni_pkg::ST_MUL) |-> (phase_q < ONE_P))
    else $error("phase not below one during interpolation");

  // A new result appears only on leaving the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == vni_pkg::ST_DONE))
    else $error("result raised outside the final state");

  // Horner evaluation takes no more than three multiplier steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vni_pkg::ST_MUL) |-> (cnt_q <= 2'd2))
    else $error("too many multiplier steps");
`endif

endmodule

// ===== tb/value_noise_interpolator_tb.sv =====
// Self-checking testbench for the value noise interpolator: directed and random
// transactions, checked against a behavioural predictor of the block or a given value.
// Depends on vni_pkg and value_noise_interpolator.
`timescale 1ns / 100ps

module value_noise_interpolator_tb;

  localparam int FRAC       = 16;
  localparam int LUT_BITS   = 8;
  localparam int LUT_LEN    = (1 << LUT_BITS) + 1;
  localparam int IN_W       = ((FRAC + 1 + 7) / 8) * 8;
  localparam int OUT_W      = ((FRAC + 3 + 7) / 8) * 8;
  localparam longint ONE    = longint'(1) << FRAC;
  localparam int SETTLE_CYC = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 160;
  localparam int DIR_ROWS    = 25;

  // One row of the directed table: either a register update or a transaction.
  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  mode;
    logic        clip;
    logic [31:0] seed;
    logic [16:0] inc;
    logic        restart;
    logic        typed;
    logic [18:0] noise;
  } dir_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [31:0]       cfg_data_i;

  // Side information travelling with the transaction being offered.
  logic              drv_typed;
  logic [18:0]       drv_typed_noise;

  // Predictor state and register copies.
  logic [1:0]        pred_mode;
  logic              pred_clip;
  logic [31:0]       pred_seed;
  logic [31:0]       gen_state;
  longint            sample_win [4];
  int unsigned       pred_phase;
  longint            cos_lut [LUT_LEN];

  logic [18:0]       noise_expected [$];
  int                mismatch_count;
  int                cycle_count;
  int                calm_left;

  dir_row_t          directed_rows [DIR_ROWS];
  logic [1:0]        phase_modes [RAND_PHASES];
  logic              phase_clips [RAND_PHASES];

  value_noise_interpolator #(
    .FRAC_BITS      (FRAC),
    .COS_TABLE_BITS (LUT_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Raised-cosine weights, (1 - cos) / 2 in Q16, from a fixed-point Taylor series
  // for the lower half and by symmetry for the upper half.
  function automatic void build_cos_lut();
    longint unsigned theta;
    longint unsigned term;
    longint          sum;
    int              half;
    half = (1 << LUT_BITS) >> 1;
    for (int k = 0; k <= half; k++) begin
      theta = (vni_pkg::PI_Q30 * longint'(k)) >> LUT_BITS;
      term  = 64'd1 << 30;
      sum   = 0;
      for (int m = 1; m <= 8; m++) begin
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = term / longint'((2 * m - 1) * (2 * m));
        if (m % 2 == 1) sum = sum + longint'(term);
        else sum = sum - longint'(term);
      end
      if (sum < 0) sum = 0;
      cos_lut[k] = (sum + (longint'(1) << (30 - FRAC))) >>> (31 - FRAC);
    end
    for (int k = half + 1; k < LUT_LEN; k++) begin
      cos_lut[k] = ONE - cos_lut[(1 << LUT_BITS) - k];
    end
  endfunction

  // Takes the top bits of the generator as a sample, then advances it.
  function automatic longint gen_draw();
    logic [31:0] x;
    longint      sample;
    x = gen_state;
    sample = longint'(x[31:32-FRAC]);
    x = x ^ (x << vni_pkg::XS_A);
    x = x ^ (x >> vni_pkg::XS_B);
    x = x ^ (x << vni_pkg::XS_C);
    gen_state = x;
    return sample;
  endfunction

  // Reloads the generator from the seed and refills the window.
  function automatic void reload_window();
    gen_state = pred_seed;
    for (int i = 0; i < 4; i++) sample_win[i] = gen_draw();
    pred_phase = 0;
  endfunction

  // Expected noise value for one accepted transaction; advances the state.
  function automatic logic [18:0] noise_predict(input logic [16:0] inc, input logic restart);
    longint v0, v1, v2, v3, t, p, q, r, val, idx;
    int unsigned step;
    if (restart) reload_window();
    if (pred_phase >= ONE) begin
      sample_win[0] = sample_win[1];
      sample_win[1] = sample_win[2];
      sample_win[2] = sample_win[3];
      sample_win[3] = gen_draw();
      pred_phase = pred_phase - int'(ONE);
    end
    v0 = sample_win[0];
    v1 = sample_win[1];
    v2 = sample_win[2];
    v3 = sample_win[3];
    t  = longint'(pred_phase);
    case (pred_mode)
      vni_pkg::MODE_STEP: begin
        val = v1;
      end
      vni_pkg::MODE_LINEAR: begin
        val = v1 + ((t * (v2 - v1)) >>> FRAC);
      end
      vni_pkg::MODE_COSINE: begin
        idx = t >>> (FRAC - LUT_BITS);
        if (idx >= LUT_LEN) idx = LUT_LEN - 1;
        val = v1 + ((cos_lut[idx] * (v2 - v1)) >>> FRAC);
      end
      default: begin
        p = (v3 - v2) - (v0 - v1);
        q = (v0 - v1) - p;
        r = v2 - v0;
        val = ((p * t) >>> FRAC) + q;
        val = ((val * t) >>> FRAC) + r;
        val = ((val * t) >>> FRAC) + v1;
        if (pred_clip) begin
          if (val < 0) val = 0;
          if (val > ONE) val = ONE;
        end
      end
    endcase
    // Saturate to the Q3.16 output range.
    if (val < -4 * ONE) val = -4 * ONE;
    if (val > 4 * ONE - 1) val = 4 * ONE - 1;
    step = (inc > 17'h10000) ? int'(ONE) : int'(inc);
    pred_phase = pred_phase + step;
    return val[18:0];
  endfunction

  // Mostly short gaps, occasionally a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Phase increment: mostly in range, with zero and over-range values mixed in.
  function automatic logic [16:0] rand_increment();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 17'd0;
    if (r < 12) return 17'($urandom_range(65536, 131071));
    if (r < 20) return 17'($urandom_range(1, 255));
    if (r < 24) return 17'h10000;
    return 17'($urandom_range(1, 65535));
  endfunction

  // Offers one transaction at a falling edge and returns after its gap.
  task automatic send(input logic [16:0] inc, input logic restart, input logic typed,
                      input logic [18:0] noise);
    int gap;
    s_axis_tvalid   <= 1'b1;
    s_axis_tdata    <= IN_W'(inc);
    s_axis_tuser    <= restart;
    drv_typed       <= typed;
    drv_typed_noise <= noise;
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    // Calm stretches with back-to-back transactions between idle periods.
    if (calm_left > 0) begin
      calm_left = calm_left - 1;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 3) calm_left = $urandom_range(20, 80);
      gap = idle_gap();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Lets every outstanding result arrive, then waits out the settle time.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (noise_expected.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles.
  task automatic write_settings(input logic [1:0] mode, input logic clip,
                                input logic [31:0] seed);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= vni_pkg::CFG_INTERP_MODE;
    cfg_data_i <= 32'(mode);
    @(negedge clk_i);
    cfg_idx_i  <= vni_pkg::CFG_CLIP_ENABLE;
    cfg_data_i <= 32'(clip);
    @(negedge clk_i);
    cfg_idx_i  <= vni_pkg::CFG_SEED;
    cfg_data_i <= seed;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    pred_mode = mode;
    pred_clip = clip;
    pred_seed = seed;
  endtask

  // Result checking and prediction at each rising edge; results are taken first.
  always @(posedge clk_i) begin
    logic [18:0] want;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (noise_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time,
                 m_axis_tdata[18:0]);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = noise_expected.pop_front();
        if (m_axis_tdata[18:0] !== want) begin
          $display("%0t: noise_value mismatch, expected %h, got %h", $time, want,
                   m_axis_tdata[18:0]);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
    if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) begin
      want = noise_predict(s_axis_tdata[16:0], s_axis_tuser);
      if (drv_typed) want = drv_typed_noise;
      noise_expected.push_back(want);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("value_noise_interpolator verification failed");
      $finish;
    end
  end

  // Output back-pressure: runs of ready separated by random stalls.
  initial begin
    int run;
    int gap;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (run) @(negedge clk_i);
      gap = idle_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    logic [31:0] seed_val;
    logic        restart_flag;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = vni_pkg::CFG_INTERP_MODE;
    cfg_data_i      = '0;
    drv_typed       = 1'b0;
    drv_typed_noise = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    calm_left       = 0;

    pred_mode = vni_pkg::RST_INTERP_MODE;
    pred_clip = vni_pkg::RST_CLIP_ENABLE;
    pred_seed = vni_pkg::RST_SEED;
    build_cos_lut();
    reload_window();

    // Seed 1 gives samples 0, 4, ... so the value at phase zero is 4 in step
    // and cubic modes; a zero seed gives zero everywhere.
    directed_rows = '{
      // Straight after reset: zero increment holds the phase, then an
      // over-range increment counts as one.
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd0,     1'b0, 1'b1, 19'd4},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd0,     1'b0, 1'b1, 19'd4},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'h1FFFF, 1'b0, 1'b1, 19'd4},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd1,     1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'h10000, 1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd65535, 1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'h10001, 1'b0, 1'b0, 19'd0},
      // Step mode after a restart from seed 1.
      '{1'b1, vni_pkg::MODE_STEP,   1'b0, 32'd1,         17'd0,     1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_STEP,   1'b0, 32'd0,         17'd12345, 1'b1, 1'b1, 19'd4},
      '{1'b0, vni_pkg::MODE_STEP,   1'b0, 32'd0,         17'd40000, 1'b0, 1'b0, 19'd0},
      // Linear; the zero seed only applies from the restart onwards.
      '{1'b1, vni_pkg::MODE_LINEAR, 1'b0, 32'd0,         17'd0,     1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_LINEAR, 1'b0, 32'd0,         17'd30000, 1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_LINEAR, 1'b0, 32'd0,         17'd50000, 1'b1, 1'b1, 19'd0},
      '{1'b0, vni_pkg::MODE_LINEAR, 1'b0, 32'd0,         17'h10000, 1'b0, 1'b1, 19'd0},
      // Cosine table across its range, all-ones seed.
      '{1'b1, vni_pkg::MODE_COSINE, 1'b1, 32'hFFFF_FFFF, 17'd0,     1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_COSINE, 1'b0, 32'd0,         17'd255,   1'b1, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_COSINE, 1'b0, 32'd0,         17'd256,   1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_COSINE, 1'b0, 32'd0,         17'd65535, 1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_COSINE, 1'b0, 32'd0,         17'd65281, 1'b0, 1'b0, 19'd0},
      // Clipped cubic.
      '{1'b1, vni_pkg::MODE_CUBIC,  1'b1, 32'h1234_5678, 17'd0,     1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd0,     1'b1, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd21845, 1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd43690, 1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd65535, 1'b0, 1'b0, 19'd0},
      '{1'b0, vni_pkg::MODE_CUBIC,  1'b0, 32'd0,         17'd1,     1'b0, 1'b0, 19'd0}
    };
    phase_modes = '{vni_pkg::MODE_CUBIC, vni_pkg::MODE_STEP, vni_pkg::MODE_LINEAR,
                    vni_pkg::MODE_COSINE, vni_pkg::MODE_CUBIC, vni_pkg::MODE_COSINE,
                    vni_pkg::MODE_LINEAR, vni_pkg::MODE_CUBIC};
    phase_clips = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    // Reset, then wait out the window fill.
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_CYC) @(negedge clk_i);

    // Directed table.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].is_cfg) begin
        settle_block();
        write_settings(directed_rows[i].mode, directed_rows[i].clip, directed_rows[i].seed);
      end else begin
        send(directed_rows[i].inc, directed_rows[i].restart, directed_rows[i].typed,
             directed_rows[i].noise);
      end
    end

    // Random phases, each opening with a restart so that its seed is used.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) seed_val = 32'hFFFF_FFFF;
      else if (ph == 3) seed_val = 32'h8000_0000;
      else seed_val = $urandom();
      settle_block();
      write_settings(phase_modes[ph], phase_clips[ph], seed_val);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        restart_flag = (n == 0) || ($urandom_range(0, 99) < 5);
        send(rand_increment(), restart_flag, 1'b0, 19'd0);
      end
    end

    // Drain and report.
    s_axis_tvalid <= 1'b0;
    while (noise_expected.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("value_noise_interpolator verification clean");
    end else begin
      $display("value_noise_interpolator verification failed");
    end
    $finish;
  end

endmodule
